/* rtl/ils_pkg.sv */
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned ELEMENT_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_ctrl_e;

  typedef struct packed {
    op_e         op;
    logic [6:0]  position;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] value_out;
    logic [5:0]  match_position;
    logic        match_found;
    logic [6:0]  entry_count;
    logic        list_empty;
  } rsp_t;

endpackage

/* rtl/ils_cell.sv */
// One list entry: holds a word, loads or takes a neighbor's word, compares to a key.
`timescale 1ns / 1ps

module ils_cell #(
  parameter int unsigned ELEMENT_WIDTH = ils_pkg::ELEMENT_WIDTH
) (
  input  logic                     clk_i,
  input  ils_pkg::cell_ctrl_e      ctrl_i,
  input  logic [ELEMENT_WIDTH-1:0] load_i,
  input  logic [ELEMENT_WIDTH-1:0] lower_i,
  input  logic [ELEMENT_WIDTH-1:0] upper_i,
  input  logic [ELEMENT_WIDTH-1:0] key_i,
  output logic [ELEMENT_WIDTH-1:0] data_o,
  output logic                     eq_o
);

  logic [ELEMENT_WIDTH-1:0] data_q;
  logic [ELEMENT_WIDTH-1:0] data_d;

  always_comb begin
    case (ctrl_i)
      ils_pkg::CELL_HOLD:       data_d = data_q;
      ils_pkg::CELL_LOAD:       data_d = load_i;
      ils_pkg::CELL_FROM_LOWER: data_d = lower_i;
      ils_pkg::CELL_FROM_UPPER: data_d = upper_i;
      default:                  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign eq_o   = (data_q == key_i);

endmodule

/* rtl/ils_tree.sv */
// Registered priority tree: picks the lowest-index hit among the cells and its word.
`timescale 1ns / 1ps

module ils_tree #(
  parameter int unsigned CAPACITY      = ils_pkg::CAPACITY,
  parameter int unsigned ELEMENT_WIDTH = ils_pkg::ELEMENT_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [CAPACITY-1:0]         leaf_hit_i,
  input  logic [ELEMENT_WIDTH-1:0]    leaf_value_i [CAPACITY],
  output logic                        hit_o,
  output logic [ELEMENT_WIDTH-1:0]    value_o,
  output logic [$clog2(CAPACITY)-1:0] index_o
);

  localparam int unsigned Levels = $clog2(CAPACITY);
  localparam int unsigned Leaves = 1 << Levels;

  logic                     all_hit   [1:2*Leaves-1];
  logic [ELEMENT_WIDTH-1:0] all_value [1:2*Leaves-1];
  logic [Levels-1:0]        all_index [1:2*Leaves-1];

  logic                     node_hit_q   [1:Leaves-1];
  logic [ELEMENT_WIDTH-1:0] node_value_q [1:Leaves-1];
  logic [Levels-1:0]        node_index_q [1:Leaves-1];

  for (genvar j = 0; j < Leaves; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_real
      assign all_hit[Leaves+j]   = leaf_hit_i[j];
      assign all_value[Leaves+j] = leaf_value_i[j];
    end else begin : g_pad
      assign all_hit[Leaves+j]   = 1'b0;
      assign all_value[Leaves+j] = '0;
    end
    assign all_index[Leaves+j] = '0;
  end

  for (genvar n = 1; n < Leaves; n++) begin : g_node
    logic                     take_right;
    logic                     hit_d;
    logic [ELEMENT_WIDTH-1:0] value_d;
    logic [Levels:0]          index_ext;

    assign all_hit[n]   = node_hit_q[n];
    assign all_value[n] = node_value_q[n];
    assign all_index[n] = node_index_q[n];

    // Prefer the lower half; the choice enters at the top of the index.
    assign take_right = !all_hit[2*n];
    assign hit_d      = all_hit[2*n] | all_hit[2*n+1];
    assign value_d    = take_right ? all_value[2*n+1] : all_value[2*n];
    assign index_ext  = {take_right, (take_right ? all_index[2*n+1] : all_index[2*n])};

    if (2*n >= Leaves) begin : g_bottom
      // Snapshot the cells only when a transaction is taken.
      always_ff @(posedge clk_i) begin
        if (load_i) begin
          node_hit_q[n]   <= hit_d;
          node_value_q[n] <= value_d;
          node_index_q[n] <= index_ext[Levels:1];
        end
      end
    end else begin : g_upper
      always_ff @(posedge clk_i) begin
        node_hit_q[n]   <= hit_d;
        node_value_q[n] <= value_d;
        node_index_q[n] <= index_ext[Levels:1];
      end
    end
  end

  assign hit_o   = node_hit_q[1];
  assign value_o = node_value_q[1];
  assign index_o = node_index_q[1];

endmodule

/* rtl/indexed_list_store.sv */
// Top level of the indexed list store: cell chain, result tree and control.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words kept in a chain of cells, one entry per cell.
// Request channel: req_i carries op, position and value_in; a transaction is taken
// at a rising edge where start_i is high and busy_o is low. busy_o stays high until
// the result has been shown.
// Result channel: rsp_o is valid for exactly one cycle, marked by done_o; the
// receiver takes it at the edge ending that cycle and cannot hold it off.
// Insert, remove, write and append shift or load the cells at the accept edge.
// Read, remove and find pass through a registered priority tree of
// log2(CAPACITY) levels: the bottom level snapshots the cells at the accept edge and
// each level above registers the one below it. done_o rises when the root holds the
// result, and the result is taken at the edge ending that cycle; the tree depth sets
// the wait. busy_o drops at that edge, so a new transaction is taken only after the
// last result has been shown.
// Reset clears the entry count and the control state; cell contents stay
// undefined until written and are never read before that.

module indexed_list_store #(
  parameter int unsigned CAPACITY      = ils_pkg::CAPACITY,
  parameter int unsigned ELEMENT_WIDTH = ils_pkg::ELEMENT_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ils_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output ils_pkg::rsp_t rsp_o
);

  localparam int unsigned Levels = $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned PosW   = (CntW > 7) ? CntW : 7;
  localparam int unsigned WaitW  = $clog2(Levels + 1);

  logic                 accept;
  logic [CntW-1:0]      count_q, count_d;
  logic                 busy_q;
  logic [WaitW-1:0]     wait_q;
  ils_pkg::op_e         op_q;
  ils_pkg::status_e     status_q;
  ils_pkg::status_e     status_d;

  logic [PosW-1:0]          pos_w;
  logic [PosW-1:0]          cnt_w;
  logic [ELEMENT_WIDTH+31:0] key_ext;
  logic [ELEMENT_WIDTH-1:0] key;
  logic                     full;
  logic                     ok;

  ils_pkg::cell_ctrl_e      cell_ctrl  [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_data  [CAPACITY];
  logic [CAPACITY-1:0]      cell_eq;
  logic [CAPACITY-1:0]      leaf_hit;

  logic                     root_hit;
  logic [ELEMENT_WIDTH-1:0] root_value;
  logic [Levels-1:0]        root_index;

  assign accept  = start_i && !busy_q;
  assign pos_w   = PosW'(req_i.position);
  assign cnt_w   = PosW'(count_q);
  assign key_ext = {{ELEMENT_WIDTH{1'b0}}, req_i.value_in};
  assign key     = key_ext[ELEMENT_WIDTH-1:0];
  assign full    = (count_q == CntW'(CAPACITY));

  always_comb begin
    status_d = ils_pkg::ST_OK;
    count_d  = count_q;
    case (req_i.op)
      ils_pkg::OP_APPEND: begin
        if (full) status_d = ils_pkg::ST_FULL;
        else      count_d  = count_q + CntW'(1);
      end
      ils_pkg::OP_INSERT: begin
        if (pos_w > cnt_w) status_d = ils_pkg::ST_RANGE;
        else if (full)     status_d = ils_pkg::ST_FULL;
        else               count_d  = count_q + CntW'(1);
      end
      ils_pkg::OP_READ, ils_pkg::OP_WRITE: begin
        if (pos_w >= cnt_w) status_d = ils_pkg::ST_RANGE;
      end
      ils_pkg::OP_REMOVE: begin
        if (pos_w >= cnt_w) status_d = ils_pkg::ST_RANGE;
        else                count_d  = count_q - CntW'(1);
      end
      ils_pkg::OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign ok = (status_d == ils_pkg::ST_OK);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [PosW-1:0] Idx = PosW'(i);
    logic [ELEMENT_WIDTH-1:0] lower;
    logic [ELEMENT_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = cell_data[i];
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    always_comb begin
      cell_ctrl[i] = ils_pkg::CELL_HOLD;
      if (accept && ok) begin
        case (req_i.op)
          ils_pkg::OP_APPEND: begin
            if (Idx == cnt_w) cell_ctrl[i] = ils_pkg::CELL_LOAD;
          end
          ils_pkg::OP_INSERT: begin
            if (Idx == pos_w)                       cell_ctrl[i] = ils_pkg::CELL_LOAD;
            else if (Idx > pos_w && Idx <= cnt_w)   cell_ctrl[i] = ils_pkg::CELL_FROM_LOWER;
          end
          ils_pkg::OP_WRITE: begin
            if (Idx == pos_w) cell_ctrl[i] = ils_pkg::CELL_LOAD;
          end
          ils_pkg::OP_REMOVE: begin
            // Close the gap: entries above the position move down one place.
            if (Idx >= pos_w && Idx + PosW'(1) < cnt_w) cell_ctrl[i] = ils_pkg::CELL_FROM_UPPER;
          end
          default: ;
        endcase
      end
    end

    always_comb begin
      case (req_i.op)
        ils_pkg::OP_READ, ils_pkg::OP_REMOVE: leaf_hit[i] = ok && (Idx == pos_w);
        ils_pkg::OP_FIND:                     leaf_hit[i] = (Idx < cnt_w) && cell_eq[i];
        default:                              leaf_hit[i] = 1'b0;
      endcase
    end

    ils_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .load_i (key),
      .lower_i(lower),
      .upper_i(upper),
      .key_i  (key),
      .data_o (cell_data[i]),
      .eq_o   (cell_eq[i])
    );
  end

  ils_tree #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_tree (
    .clk_i       (clk_i),
    .load_i      (accept),
    .leaf_hit_i  (leaf_hit),
    .leaf_value_i(cell_data),
    .hit_o       (root_hit),
    .value_o     (root_value),
    .index_o     (root_index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      wait_q   <= '0;
      op_q     <= ils_pkg::OP_CLEAR;
      status_q <= ils_pkg::ST_OK;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        busy_q   <= 1'b1;
        wait_q   <= WaitW'(Levels - 1);
        op_q     <= req_i.op;
        status_q <= status_d;
      end else if (busy_q) begin
        // Hold until the tree root carries this transaction, then drop busy.
        if (wait_q == '0) busy_q <= 1'b0;
        else              wait_q <= wait_q - WaitW'(1);
      end
    end
  end

  logic                     want_value;
  logic                     want_match;
  logic [ELEMENT_WIDTH+31:0] value_ext;
  logic [Levels+5:0]        index_ext;
  logic [CntW+6:0]          count_ext;

  assign want_value = (status_q == ils_pkg::ST_OK) &&
                      (op_q == ils_pkg::OP_READ || op_q == ils_pkg::OP_REMOVE);
  assign want_match = (op_q == ils_pkg::OP_FIND) && root_hit;
  assign value_ext  = {32'd0, root_value};
  assign index_ext  = {6'd0, root_index};
  assign count_ext  = {7'd0, count_q};

  assign busy_o = busy_q;
  assign done_o = busy_q && (wait_q == '0);

  always_comb begin
    rsp_o.status         = status_q;
    rsp_o.value_out      = want_value ? value_ext[31:0] : 32'd0;
    rsp_o.match_position = want_match ? index_ext[5:0] : 6'd0;
    rsp_o.match_found    = want_match;
    rsp_o.entry_count    = count_ext[6:0];
    rsp_o.list_empty     = (count_q == '0);
  end

endmodule

/* tb/sv/indexed_list_store_test.sv */
// Self-checking test of the indexed list store: directed, capacity and random list traffic.
`timescale 1ns / 1ps

module indexed_list_store_test;

  logic           clk_i;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  ils_pkg::req_t  req_i   = '0;
  logic           busy_o;
  logic           done_o;
  ils_pkg::rsp_t  rsp_o;

  // Predicted list contents and the results still owed by the block.
  logic [ils_pkg::ELEMENT_WIDTH-1:0] list_words [ils_pkg::CAPACITY];
  int                                list_count = 0;
  ils_pkg::rsp_t                     pending_results [$];
  int unsigned                       failure_count = 0;

  indexed_list_store u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("indexed_list_store_test: done, errors");
    $finish;
  end

  // Apply one request to the predicted list and return the result it must produce.
  function automatic ils_pkg::rsp_t apply_list_op(ils_pkg::req_t r);
    ils_pkg::rsp_t                     o;
    logic [ils_pkg::ELEMENT_WIDTH-1:0] word;
    int                                pos;
    o      = '0;
    o.status = ils_pkg::ST_OK;
    word   = r.value_in[ils_pkg::ELEMENT_WIDTH-1:0];
    pos    = int'(r.position);
    case (r.op)
      ils_pkg::OP_APPEND: begin
        if (list_count >= ils_pkg::CAPACITY) begin
          o.status = ils_pkg::ST_FULL;
        end else begin
          list_words[list_count] = word;
          list_count++;
        end
      end
      ils_pkg::OP_INSERT: begin
        // Range check wins over the full check.
        if (pos > list_count) begin
          o.status = ils_pkg::ST_RANGE;
        end else if (list_count >= ils_pkg::CAPACITY) begin
          o.status = ils_pkg::ST_FULL;
        end else begin
          for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_count++;
        end
      end
      ils_pkg::OP_READ: begin
        if (pos >= list_count) o.status = ils_pkg::ST_RANGE;
        else o.value_out = list_words[pos];
      end
      ils_pkg::OP_WRITE: begin
        if (pos >= list_count) o.status = ils_pkg::ST_RANGE;
        else list_words[pos] = word;
      end
      ils_pkg::OP_REMOVE: begin
        if (pos >= list_count) begin
          o.status = ils_pkg::ST_RANGE;
        end else begin
          o.value_out = list_words[pos];
          for (int i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      ils_pkg::OP_FIND: begin
        for (int i = 0; i < list_count; i++) begin
          if (!o.match_found && list_words[i] == word) begin
            o.match_position = i[5:0];
            o.match_found    = 1'b1;
          end
        end
      end
      ils_pkg::OP_CLEAR: list_count = 0;
      default: ;
    endcase
    o.entry_count = list_count[6:0];
    o.list_empty  = (list_count == 0);
    return o;
  endfunction

  // Mix of corner words, a small set that forces duplicates, and full random words.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h0000_0001;
      3, 4: return 32'(($urandom_range(7)));
      default: return $urandom;
    endcase
  endfunction

  // Hold the request until the block takes it, then record its expected result.
  task automatic issue_request(ils_pkg::op_e op, logic [6:0] pos, logic [31:0] val,
                               int unsigned idle_pct);
    ils_pkg::req_t r;
    r.op       = op;
    r.position = pos;
    r.value_in = val;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    pending_results.push_back(apply_list_op(r));
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failure_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ils_pkg::rsp_t want;
    if (done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        failure_count++;
        $display("%0t: result with no transaction outstanding: expected none, actual %p",
                 $time, rsp_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, rsp_o.status);
        check_field("value_out", want.value_out, rsp_o.value_out);
        check_field("match_position", want.match_position, rsp_o.match_position);
        check_field("match_found", want.match_found, rsp_o.match_found);
        check_field("entry_count", want.entry_count, rsp_o.entry_count);
        check_field("list_empty", want.list_empty, rsp_o.list_empty);
      end
    end
  end

  // Empty-list errors, ordinary edits, range errors, find hit and miss, clear.
  task automatic test_basic_ops();
    issue_request(ils_pkg::OP_READ,   7'd0,  32'h0, 0);
    issue_request(ils_pkg::OP_WRITE,  7'd0,  32'h1, 0);
    issue_request(ils_pkg::OP_REMOVE, 7'd0,  32'h0, 0);
    issue_request(ils_pkg::OP_FIND,   7'd0,  32'h0, 0);
    issue_request(ils_pkg::OP_INSERT, 7'd1,  32'h2, 0);
    issue_request(ils_pkg::OP_INSERT, 7'd0,  32'hFFFF_FFFF, 0);
    issue_request(ils_pkg::OP_APPEND, 7'd0,  32'h0000_0000, 0);
    issue_request(ils_pkg::OP_APPEND, 7'd64, 32'h8000_0001, 0);
    issue_request(ils_pkg::OP_INSERT, 7'd3,  32'h0000_1234, 0);
    issue_request(ils_pkg::OP_INSERT, 7'd1,  32'hAAAA_5555, 0);
    issue_request(ils_pkg::OP_READ,   7'd0,  32'h0, 0);
    issue_request(ils_pkg::OP_READ,   7'd4,  32'h0, 0);
    issue_request(ils_pkg::OP_READ,   7'd5,  32'h0, 0);
    issue_request(ils_pkg::OP_WRITE,  7'd2,  32'h0000_0000, 0);
    issue_request(ils_pkg::OP_FIND,   7'd0,  32'h0000_0000, 0);
    issue_request(ils_pkg::OP_FIND,   7'd0,  32'h1234_5678, 0);
    issue_request(ils_pkg::OP_READ,   7'd64, 32'h0, 0);
    issue_request(ils_pkg::OP_REMOVE, 7'd1,  32'h0, 0);
    issue_request(ils_pkg::OP_REMOVE, 7'd3,  32'h0, 0);
    issue_request(ils_pkg::OP_INSERT, 7'd64, 32'h5555_AAAA, 0);
    issue_request(ils_pkg::OP_WRITE,  7'd64, 32'h5555_AAAA, 0);
    issue_request(ils_pkg::OP_CLEAR,  7'd0,  32'h0, 0);
    issue_request(ils_pkg::OP_CLEAR,  7'd0,  32'h0, 0);
    issue_request(ils_pkg::OP_APPEND, 7'd0,  32'h5A5A_5A5A, 0);
    issue_request(ils_pkg::OP_FIND,   7'd0,  32'h5A5A_5A5A, 0);
  endtask

  // Fill to capacity, hit the full errors, work the top entry, refill.
  task automatic test_capacity_limits();
    issue_request(ils_pkg::OP_CLEAR, 7'd0, 32'h0, 34);
    for (int k = 0; k < ils_pkg::CAPACITY - 2; k++) begin
      issue_request(ils_pkg::OP_APPEND, 7'd0, pick_word(), 34);
    end
    issue_request(ils_pkg::OP_INSERT, 7'd0,  pick_word(), 34);
    issue_request(ils_pkg::OP_INSERT, 7'd31, 32'hFFFF_FFFF, 34);
    issue_request(ils_pkg::OP_APPEND, 7'd0,  32'h0000_0001, 34);
    issue_request(ils_pkg::OP_INSERT, 7'd64, 32'h0000_0002, 34);
    issue_request(ils_pkg::OP_INSERT, 7'd10, 32'h0000_0003, 34);
    issue_request(ils_pkg::OP_READ,   7'd63, 32'h0, 34);
    issue_request(ils_pkg::OP_READ,   7'd64, 32'h0, 34);
    issue_request(ils_pkg::OP_WRITE,  7'd63, 32'hC0DE_0001, 34);
    issue_request(ils_pkg::OP_FIND,   7'd0,  32'hC0DE_0001, 34);
    issue_request(ils_pkg::OP_REMOVE, 7'd63, 32'h0, 34);
    issue_request(ils_pkg::OP_REMOVE, 7'd0,  32'h0, 34);
    issue_request(ils_pkg::OP_INSERT, 7'd62, pick_word(), 34);
    issue_request(ils_pkg::OP_APPEND, 7'd0,  pick_word(), 34);
    issue_request(ils_pkg::OP_CLEAR,  7'd0,  32'h0, 34);
  endtask

  // Random traffic in stretches that grow, shrink or hold the list, so the count sweeps
  // from empty to full; positions and find values mostly hit live entries.
  task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct);
    int unsigned  mode;
    int unsigned  roll;
    int unsigned  grow_pct;
    int unsigned  shrink_pct;
    ils_pkg::op_e op;
    logic [6:0]   pos;
    logic [31:0]  val;
    mode = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 40 == 0) mode = $urandom_range(2);
      grow_pct   = (mode == 0) ? 55 : (mode == 1) ? 12 : 30;
      shrink_pct = (mode == 0) ? 10 : (mode == 1) ? 40 : 18;
      roll = $urandom_range(99);
      if (roll < 2) begin
        op = ils_pkg::OP_CLEAR;
      end else if (roll < 2 + grow_pct) begin
        op = ($urandom_range(1)) ? ils_pkg::OP_APPEND : ils_pkg::OP_INSERT;
      end else if (roll < 2 + grow_pct + shrink_pct) begin
        op = ils_pkg::OP_REMOVE;
      end else begin
        case ($urandom_range(2))
          0: op = ils_pkg::OP_READ;
          1: op = ils_pkg::OP_WRITE;
          default: op = ils_pkg::OP_FIND;
        endcase
      end
      if ($urandom_range(99) < 15) pos = 7'($urandom_range(64));
      else if (op == ils_pkg::OP_INSERT) pos = 7'($urandom_range(list_count));
      else if (list_count > 0) pos = 7'($urandom_range(list_count - 1));
      else pos = 7'd0;
      val = pick_word();
      if (op == ils_pkg::OP_FIND && list_count > 0 && $urandom_range(99) < 60)
        val = list_words[$urandom_range(list_count - 1)];
      issue_request(op, pos, val, idle_pct);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_capacity_limits();
    test_random_traffic(360, 34);
    test_random_traffic(360, 63);
    test_random_traffic(360, 0);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("indexed_list_store_test: done, clean");
    end else begin
      $display("indexed_list_store_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_tree.sv
rtl/indexed_list_store.sv
tb/sv/indexed_list_store_test.sv
